/* rtl/v3mu_pkg.sv */
// types, constants and helper functions shared by the vector unit
package v3mu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 2 * WORD_BITS + 2;
  localparam int LEN_W     = ACC_W / 2;
  localparam int NUM_W     = WORD_BITS + FRAC_BITS;
  localparam int FQ_DEPTH  = 4;
  localparam int FQ_AW     = $clog2(FQ_DEPTH);

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_SCALE = 3'd2,
    FN_DOT   = 3'd3,
    FN_CROSS = 3'd4,
    FN_MAG   = 3'd5,
    FN_NORM  = 3'd6,
    FN_RSVD  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ROOT,
    BK_RND,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic [2:0]                  func;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] r_scalar;
    logic                        overflow;
    logic                        zero_length;
  } out_item_t;

  typedef struct packed {
    logic use_mul;
    logic use_root;
    logic use_div;
  } op_class_t;

  typedef struct packed {
    in_item_t  item;
    op_class_t cls;
  } q_entry_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        ovf;
  } sat_t;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sext_w(input logic signed [WORD_BITS-1:0] v);
    return {{(ACC_W-WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
    sat_t r;
    r.val = v[WORD_BITS-1:0];
    r.ovf = 1'b0;
    if (v > SAT_HI) begin
      r.val = {1'b0, {(WORD_BITS-1){1'b1}}};
      r.ovf = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = {1'b1, {(WORD_BITS-1){1'b0}}};
      r.ovf = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/v3mu_front.sv */
// front end: accepts transactions, classifies the operation and queues them
module v3mu_front import v3mu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  output q_entry_t q_entry,
  input  logic     q_pop
);

  q_entry_t          mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FQ_AW:0]    count_r, count_nxt;
  logic              push;
  op_class_t         cls;
  func_t             fn;

  always_comb begin
    fn = func_t'(in_item.func);
    cls = '0;
    case (fn)
      FN_SCALE, FN_DOT, FN_CROSS: begin
        cls.use_mul = 1'b1;
      end
      FN_MAG: begin
        cls.use_mul  = 1'b1;
        cls.use_root = 1'b1;
      end
      FN_NORM: begin
        cls.use_mul  = 1'b1;
        cls.use_root = 1'b1;
        cls.use_div  = 1'b1;
      end
      default: begin
        cls = '0;
      end
    endcase
  end

  assign in_stall = (count_r == (FQ_AW+1)'(FQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (FQ_AW+1)'(push) - (FQ_AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{item: in_item, cls: cls};
    end
  end

endmodule

/* rtl/v3mu_back.sv */
// back end: shared multiplier, bit-serial square root, three divider lanes, result register
module v3mu_back import v3mu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [2:0] MUL_LAST = 3'd6;
  localparam int         DC_W     = $clog2(NUM_W);

  bk_state_t state_r, state_nxt;
  in_item_t  item_r;
  op_class_t cls_r;
  func_t     fn;
  logic [2:0] step_r;

  logic signed [WORD_BITS-1:0]   m_a, m_b;
  logic [1:0]                    m_t;
  logic                          m_neg, m_en;
  logic signed [2*WORD_BITS-1:0] prod_nxt, prod_r;
  logic [1:0]                    prod_t_r;
  logic                          prod_neg_r, prod_v_r;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       acc_r [3];
  logic signed [ACC_W-1:0]       acc_nxt [3];

  logic [ACC_W-1:0] sq_s_r, sq_res_r, bit_r;
  logic [ACC_W-1:0] sq_t, sq_s_nxt, sq_res_nxt, len_full;
  logic [LEN_W-1:0] len_r;

  logic [NUM_W-1:0] dn_r [3];
  logic [LEN_W-1:0] dr_r [3];
  logic [NUM_W-1:0] dn_nxt [3];
  logic [LEN_W-1:0] dr_nxt [3];
  logic [LEN_W:0]   d_sh [3];
  logic [DC_W-1:0]  dc_r;

  logic signed [WORD_BITS-1:0] av [3];
  logic signed [WORD_BITS-1:0] bv [3];
  logic [WORD_BITS-1:0]        a_abs [3];
  logic signed [ACC_W-1:0]     rv [3];
  logic [NUM_W:0]              q_rnd [3];
  logic signed [ACC_W-1:0]     q_ext [3];
  sat_t                        sv [3];
  sat_t                        ss;
  logic                        zl;
  out_item_t                   fin_item, out_item_r;
  logic                        out_valid_r;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  assign fn = func_t'(item_r.func);

  always_comb begin
    av[0] = item_r.a_x;
    av[1] = item_r.a_y;
    av[2] = item_r.a_z;
    bv[0] = item_r.b_x;
    bv[1] = item_r.b_y;
    bv[2] = item_r.b_z;
    for (int j = 0; j < 3; j++) begin
      a_abs[j] = av[j][WORD_BITS-1] ? WORD_BITS'(-av[j]) : WORD_BITS'(av[j]);
    end
  end

  // operand schedule for the shared multiplier
  always_comb begin
    m_a   = item_r.a_x;
    m_b   = item_r.b_x;
    m_t   = 2'd0;
    m_neg = 1'b0;
    m_en  = 1'b0;
    case (fn)
      FN_SCALE: begin
        m_b = item_r.scale_factor;
        case (step_r)
          3'd0: begin m_a = item_r.a_x; m_t = 2'd0; m_en = 1'b1; end
          3'd1: begin m_a = item_r.a_y; m_t = 2'd1; m_en = 1'b1; end
          3'd2: begin m_a = item_r.a_z; m_t = 2'd2; m_en = 1'b1; end
          default: begin m_en = 1'b0; end
        endcase
      end
      FN_DOT: begin
        case (step_r)
          3'd0: begin m_a = item_r.a_x; m_b = item_r.b_x; m_en = 1'b1; end
          3'd1: begin m_a = item_r.a_y; m_b = item_r.b_y; m_en = 1'b1; end
          3'd2: begin m_a = item_r.a_z; m_b = item_r.b_z; m_en = 1'b1; end
          default: begin m_en = 1'b0; end
        endcase
      end
      FN_CROSS: begin
        case (step_r)
          3'd0: begin m_a = item_r.a_y; m_b = item_r.b_z; m_t = 2'd0; m_en = 1'b1; end
          3'd1: begin
            m_a = item_r.a_z; m_b = item_r.b_y; m_t = 2'd0; m_neg = 1'b1; m_en = 1'b1;
          end
          3'd2: begin m_a = item_r.a_z; m_b = item_r.b_x; m_t = 2'd1; m_en = 1'b1; end
          3'd3: begin
            m_a = item_r.a_x; m_b = item_r.b_z; m_t = 2'd1; m_neg = 1'b1; m_en = 1'b1;
          end
          3'd4: begin m_a = item_r.a_x; m_b = item_r.b_y; m_t = 2'd2; m_en = 1'b1; end
          3'd5: begin
            m_a = item_r.a_y; m_b = item_r.b_x; m_t = 2'd2; m_neg = 1'b1; m_en = 1'b1;
          end
          default: begin m_en = 1'b0; end
        endcase
      end
      FN_MAG, FN_NORM: begin
        case (step_r)
          3'd0: begin m_a = item_r.a_x; m_b = item_r.a_x; m_en = 1'b1; end
          3'd1: begin m_a = item_r.a_y; m_b = item_r.a_y; m_en = 1'b1; end
          3'd2: begin m_a = item_r.a_z; m_b = item_r.a_z; m_en = 1'b1; end
          default: begin m_en = 1'b0; end
        endcase
      end
      default: begin
        m_en = 1'b0;
      end
    endcase
  end

  assign prod_nxt = m_a * m_b;
  assign prod_ext = {{(ACC_W-2*WORD_BITS){prod_r[2*WORD_BITS-1]}}, prod_r};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_nxt[j] = acc_r[j];
      if (prod_v_r && (prod_t_r == 2'(j))) begin
        acc_nxt[j] = prod_neg_r ? acc_r[j] - prod_ext : acc_r[j] + prod_ext;
      end
    end
  end

  // one root digit a cycle
  always_comb begin
    sq_t       = sq_res_r + bit_r;
    sq_s_nxt   = sq_s_r;
    sq_res_nxt = sq_res_r >> 1;
    if (sq_s_r >= sq_t) begin
      sq_s_nxt   = sq_s_r - sq_t;
      sq_res_nxt = (sq_res_r >> 1) + bit_r;
    end
    len_full = sq_res_r + ACC_W'(sq_s_r > sq_res_r);
  end

  // restoring division, one quotient bit per lane a cycle
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_sh[j]   = {dr_r[j], dn_r[j][NUM_W-1]};
      dn_nxt[j] = {dn_r[j][NUM_W-2:0], 1'b0};
      dr_nxt[j] = d_sh[j][LEN_W-1:0];
      if (d_sh[j] >= {1'b0, len_r}) begin
        dr_nxt[j]    = LEN_W'(d_sh[j] - {1'b0, len_r});
        dn_nxt[j][0] = 1'b1;
      end
    end
  end

  always_comb begin
    ss = '0;
    zl = 1'b0;
    for (int j = 0; j < 3; j++) begin
      sv[j]    = '0;
      rv[j]    = (acc_r[j] + RND_HALF) >>> FRAC_BITS;
      q_rnd[j] = {1'b0, dn_r[j]} + (NUM_W+1)'({dr_r[j], 1'b0} >= {1'b0, len_r});
      q_ext[j] = {{(ACC_W-NUM_W-1){1'b0}}, q_rnd[j]};
      if (av[j][WORD_BITS-1]) begin
        q_ext[j] = -q_ext[j];
      end
    end
    case (fn)
      FN_ADD: begin
        for (int j = 0; j < 3; j++) sv[j] = sat_word(sext_w(av[j]) + sext_w(bv[j]));
      end
      FN_SUB: begin
        for (int j = 0; j < 3; j++) sv[j] = sat_word(sext_w(av[j]) - sext_w(bv[j]));
      end
      FN_SCALE, FN_CROSS: begin
        for (int j = 0; j < 3; j++) sv[j] = sat_word(rv[j]);
      end
      FN_DOT: begin
        ss = sat_word(rv[0]);
      end
      FN_MAG: begin
        ss = sat_word({{(ACC_W-LEN_W){1'b0}}, len_r});
      end
      FN_NORM: begin
        if (len_r == '0) begin
          zl = 1'b1;
        end else begin
          for (int j = 0; j < 3; j++) sv[j] = sat_word(q_ext[j]);
        end
      end
      default: begin
        ss = '0;
      end
    endcase
    fin_item.r_x         = sv[0].val;
    fin_item.r_y         = sv[1].val;
    fin_item.r_z         = sv[2].val;
    fin_item.r_scalar    = ss.val;
    fin_item.overflow    = sv[0].ovf | sv[1].ovf | sv[2].ovf | ss.ovf;
    fin_item.zero_length = zl;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = q_entry.cls.use_mul ? BK_MUL : BK_FIN;
        end
      end
      BK_MUL: begin
        if (step_r == MUL_LAST) begin
          state_nxt = cls_r.use_root ? BK_ROOT : BK_FIN;
        end
      end
      BK_ROOT: begin
        if (bit_r[0]) begin
          state_nxt = BK_RND;
        end
      end
      BK_RND: begin
        state_nxt = (cls_r.use_div && (len_full != '0)) ? BK_DIV : BK_FIN;
      end
      BK_DIV: begin
        if (dc_r == '0) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!out_stall) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == BK_OUT);
      prod_v_r    <= (state_r == BK_MUL) && m_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    prod_t_r   <= m_t;
    prod_neg_r <= m_neg;
    case (state_r)
      BK_IDLE: begin
        item_r <= q_entry.item;
        cls_r  <= q_entry.cls;
        step_r <= '0;
        for (int j = 0; j < 3; j++) acc_r[j] <= '0;
      end
      BK_MUL: begin
        step_r <= step_r + 1'b1;
        for (int j = 0; j < 3; j++) acc_r[j] <= acc_nxt[j];
        sq_s_r   <= acc_nxt[0];
        sq_res_r <= '0;
        bit_r    <= {2'b01, {(ACC_W-2){1'b0}}};
      end
      BK_ROOT: begin
        sq_s_r   <= sq_s_nxt;
        sq_res_r <= sq_res_nxt;
        bit_r    <= bit_r >> 2;
      end
      BK_RND: begin
        len_r <= len_full[LEN_W-1:0];
        dc_r  <= DC_W'(NUM_W - 1);
        for (int j = 0; j < 3; j++) begin
          dn_r[j] <= {a_abs[j], {FRAC_BITS{1'b0}}};
          dr_r[j] <= '0;
        end
      end
      BK_DIV: begin
        dc_r <= dc_r - 1'b1;
        for (int j = 0; j < 3; j++) begin
          dn_r[j] <= dn_nxt[j];
          dr_r[j] <= dr_nxt[j];
        end
      end
      BK_FIN: begin
        out_item_r <= fin_item;
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/vector3_math_unit.sv */
// top level of the Q16.16 three-component vector unit
// Each transaction enters a four-entry queue at the front, so a new one is taken in every cycle
// until the queue is full, also while a result waits at the output. The back end works on one
// transaction at a time: add, subtract and the unused code skip the multiplier; scale, dot and
// cross make one pass through the shared 32x32 multiplier per product (six for cross) plus drain;
// magnitude adds a 33-step bit-serial square root, and normalize a further 48 steps of three
// restoring divider lanes run side by side. A result held at the output by stall delays the
// next one. There is no configuration and no state carried between transactions.
module vector3_math_unit import v3mu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;

  v3mu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  v3mu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/v3mu_checker.sv */
// port checker for the vector unit, bound to the top level
module v3mu_checker import v3mu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input transaction changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result transaction changed");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_length |->
      out_item.r_x == '0 && out_item.r_y == '0 && out_item.r_z == '0 &&
      out_item.r_scalar == '0 && !out_item.overflow)
    else $error("zero length result not all zero");

  a_scalar_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.r_scalar != '0 |->
      out_item.r_x == '0 && out_item.r_y == '0 && out_item.r_z == '0)
    else $error("scalar result carries a vector");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("unit not empty after reset");

endmodule

bind vector3_math_unit v3mu_checker u_v3mu_checker (.*);

/* sim/tb_top.sv */
// self-checking testbench for the vector unit: directed table, then random transactions
`timescale 1ns / 100ps

module tb_top;
  import v3mu_pkg::*;

  localparam int N_RANDOM    = 1100;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [ACC_W+2:0]     acc_t;

  typedef struct {
    in_item_t  stim;
    logic      has_exp;
    out_item_t exp;
  } vec_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  out_item_t result_q[$];
  vec_row_t  dir_rows[$];
  int        mismatches = 0;
  int        cycles;
  logic      timed_out = 1'b0;
  logic      hold_off;
  logic      no_idle;
  logic      stim_done;

  vector3_math_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // product sum reduced by the fraction bits, ties towards plus infinity
  function automatic acc_t fx_round(input acc_t v);
    return (v + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic word_t fx_sat(input acc_t v, inout logic ovf);
    acc_t hi, lo;
    hi = acc_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) begin
      ovf = 1'b1;
      return word_t'(hi);
    end
    if (v < lo) begin
      ovf = 1'b1;
      return word_t'(lo);
    end
    return word_t'(v);
  endfunction

  function automatic logic [127:0] isqrt_round(input logic [127:0] s);
    logic [127:0] res, t;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      t = res + (128'd1 << (2 * i));
      if (s >= t) begin
        s = s - t;
        res = (res >> 1) + (128'd1 << (2 * i));
      end else begin
        res = res >> 1;
      end
    end
    if (s > res) res = res + 1;
    return res;
  endfunction

  function automatic out_item_t vector_result(input in_item_t it);
    out_item_t o;
    acc_t a[3], b[3], r[3], sc, sf;
    logic [127:0] ss, len, num, q, rem;
    logic vec, scal, ovf;
    a[0] = acc_t'(it.a_x); a[1] = acc_t'(it.a_y); a[2] = acc_t'(it.a_z);
    b[0] = acc_t'(it.b_x); b[1] = acc_t'(it.b_y); b[2] = acc_t'(it.b_z);
    sf = acc_t'(it.scale_factor);
    r[0] = '0; r[1] = '0; r[2] = '0; sc = '0;
    vec = 1'b1; scal = 1'b0; ovf = 1'b0;
    o = '0;
    case (func_t'(it.func))
      FN_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      FN_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      FN_SCALE: for (int i = 0; i < 3; i++) r[i] = fx_round(a[i] * sf);
      FN_DOT: begin
        sc = fx_round(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
        vec = 1'b0; scal = 1'b1;
      end
      FN_CROSS: begin
        r[0] = fx_round(a[1] * b[2] - a[2] * b[1]);
        r[1] = fx_round(a[2] * b[0] - a[0] * b[2]);
        r[2] = fx_round(a[0] * b[1] - a[1] * b[0]);
      end
      FN_MAG, FN_NORM: begin
        ss = 128'(a[0] * a[0]) + 128'(a[1] * a[1]) + 128'(a[2] * a[2]);
        len = isqrt_round(ss);
        if (func_t'(it.func) == FN_MAG) begin
          sc = acc_t'(len);
          vec = 1'b0; scal = 1'b1;
        end else if (len == 0) begin
          o.zero_length = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            num = 128'(a[i] < 0 ? -a[i] : a[i]) << FRAC_BITS;
            q = num / len;
            rem = num % len;
            if ((rem << 1) >= len) q = q + 1;
            r[i] = a[i] < 0 ? -acc_t'(q) : acc_t'(q);
          end
        end
      end
      default: vec = 1'b0;
    endcase
    if (vec) begin
      o.r_x = fx_sat(r[0], ovf);
      o.r_y = fx_sat(r[1], ovf);
      o.r_z = fx_sat(r[2], ovf);
    end
    if (scal) o.r_scalar = fx_sat(sc, ovf);
    o.overflow = ovf;
    return o;
  endfunction

  function automatic in_item_t mk_item(input func_t f, input word_t ax, ay, az, bx, by, bz, s);
    in_item_t it;
    it.func = f;
    it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.b_x = bx; it.b_y = by; it.b_z = bz;
    it.scale_factor = s;
    return it;
  endfunction

  function automatic out_item_t mk_res(input word_t x, y, z, s, input logic ov, zl);
    out_item_t o;
    o.r_x = x; o.r_y = y; o.r_z = z; o.r_scalar = s;
    o.overflow = ov; o.zero_length = zl;
    return o;
  endfunction

  function automatic word_t rnd_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 8)) <<< 16;
      2: return -(word_t'($urandom_range(0, 8)) <<< 16);
      3: return word_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      4: return word_t'($signed($urandom) >>> $urandom_range(8, 24));
      default: return word_t'($urandom_range(0, 3)) - 2;
    endcase
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    it.func = 3'($urandom_range(0, 7));
    it.a_x = rnd_word(); it.a_y = rnd_word(); it.a_z = rnd_word();
    it.b_x = rnd_word(); it.b_y = rnd_word(); it.b_z = rnd_word();
    it.scale_factor = rnd_word();
    if (it.func == FN_NORM && $urandom_range(0, 9) == 0) begin
      it.a_x = '0; it.a_y = '0; it.a_z = '0;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input logic has_exp, input out_item_t e);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    result_q.push_back(has_exp ? e : vector_result(it));
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      in_item  <= rnd_item();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic add_row(input in_item_t it, input logic has, input out_item_t e);
    vec_row_t row;
    row.stim = it; row.has_exp = has; row.exp = e;
    dir_rows.push_back(row);
  endtask

  initial begin
    word_t mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    add_row(mk_item(FN_ADD, 1, 2, 3, 4, 5, 6, 0), 1, mk_res(5, 7, 9, 0, 0, 0));
    add_row(mk_item(FN_ADD, mx, mn, 0, 1, -1, 0, 0), 1, mk_res(mx, mn, 0, 0, 1, 0));
    add_row(mk_item(FN_SUB, mn, mx, 7, 1, -1, 7, 0), 1, mk_res(mn, mx, 0, 0, 1, 0));
    add_row(mk_item(FN_SCALE, 32'h10000, -32'sh20000, 3, 0, 0, 0, 32'h20000), 1,
            mk_res(32'h20000, -32'sh40000, 6, 0, 0, 0));
    add_row(mk_item(FN_SCALE, mx, mn, mx, 0, 0, 0, mn), 1, mk_res(mn, mx, mn, 0, 1, 0));
    add_row(mk_item(FN_SCALE, 1, -1, 3, 0, 0, 0, 32'h8000), 0, '0);
    add_row(mk_item(FN_DOT, 32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h10000,
            32'h10000, 0), 1, mk_res(0, 0, 0, 32'h60000, 0, 0));
    add_row(mk_item(FN_DOT, mx, mx, mx, mx, mx, mx, 0), 1, mk_res(0, 0, 0, mx, 1, 0));
    add_row(mk_item(FN_DOT, mn, mn, mn, mx, mx, mx, 0), 1, mk_res(0, 0, 0, mn, 1, 0));
    add_row(mk_item(FN_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0), 1,
            mk_res(0, 0, 32'h10000, 0, 0, 0));
    add_row(mk_item(FN_CROSS, mx, mn, mx, mn, mx, mn, 0), 0, '0);
    add_row(mk_item(FN_MAG, 32'h30000, 32'h40000, 0, 0, 0, 0, 0), 1,
            mk_res(0, 0, 0, 32'h50000, 0, 0));
    add_row(mk_item(FN_MAG, mn, mn, mn, 0, 0, 0, 0), 1, mk_res(0, 0, 0, mx, 1, 0));
    add_row(mk_item(FN_MAG, 1, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(FN_NORM, 0, 0, 0, 5, 5, 5, 5), 1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(mk_item(FN_NORM, 32'h30000, 0, -32'sh40000, 0, 0, 0, 0), 1,
            mk_res(32'h999a, 0, -32'shcccd, 0, 0, 0));
    add_row(mk_item(FN_NORM, mn, mx, 1, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(FN_NORM, 1, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(FN_RSVD, mx, mn, mx, mn, mx, mn, mx), 1, '0);
    add_row(mk_item(FN_ADD, -1, -1, -1, -1, -1, -1, -1), 1, mk_res(-2, -2, -2, 0, 0, 0));
  end

  initial begin
    vec_row_t row;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    no_idle   = 1'b0;
    stim_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.stim, row.has_exp, row.exp);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 300 && n < 450);
      if (n == 600) begin
        in_valid <= 1'b0;
        wait (result_q.size() == 0);
        @(posedge clk);
      end
      send_item(rnd_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stall, one long hold-off while the sender keeps offering
  initial begin
    hold_off  = 1'b0;
    wait (rst_n);
    repeat (1500) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 14);
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", out_item);
      end else begin
        e = result_q.pop_front();
        if (out_item.r_x !== e.r_x || out_item.r_y !== e.r_y || out_item.r_z !== e.r_z ||
            out_item.r_scalar !== e.r_scalar || out_item.overflow !== e.overflow ||
            out_item.zero_length !== e.zero_length) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_item);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    fork
      begin
        wait (stim_done && result_q.size() == 0);
        repeat (200) @(posedge clk);
      end
      begin
        while (cycles < CYCLE_LIMIT) begin
          @(posedge clk);
          cycles++;
        end
        timed_out = 1'b1;
      end
    join_any
    if (mismatches == 0 && !timed_out && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/v3mu_pkg.sv
rtl/v3mu_front.sv
rtl/v3mu_back.sv
rtl/vector3_math_unit.sv
rtl/v3mu_checker.sv
sim/tb_top.sv
